/* design/sbas_message_crc24q_framer_core_defines.svh */
// assertion macros shared by the framer rtl
// no dependencies; included by modules that carry assertions
`ifndef SBAS_MESSAGE_CRC24Q_FRAMER_CORE_DEFINES_SVH
`define SBAS_MESSAGE_CRC24Q_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scf assertion failed");

// next-cycle implication, disabled during reset
`define SCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scf assertion failed");

`endif

/* design/scf_pkg.sv */
// package for the sbas crc-24q framer: queue entry type, constants, crc functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    localparam logic [23:0] CRC_POLY = 24'h864CFB;
    localparam logic [4:0]  LAST_POS = 5'd28;
    localparam logic [1:0]  SUB_LAST = 2'd3;
    localparam logic [7:0]  MSG_MASK = 8'hC0;

    typedef struct packed {
        logic        last;
        logic [7:0]  data;
        logic [23:0] crc;
    } t_entry;

    function automatic logic [23:0] crc_bit(input logic [23:0] crc, input logic b);
        logic fb;
        fb = crc[23] ^ b;
        return fb ? ({crc[22:0], 1'b0} ^ CRC_POLY) : {crc[22:0], 1'b0};
    endfunction

    // full byte, msb first
    function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] d);
        logic [23:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = crc_bit(c, d[i]);
        end
        return c;
    endfunction

    // top two bits only
    function automatic logic [23:0] crc_top2(input logic [23:0] crc, input logic [7:0] d);
        return crc_bit(crc_bit(crc, d[7]), d[6]);
    endfunction

endpackage

`default_nettype wire

/* design/scf_front.sv */
// front end: accepts message bytes, tracks position, runs the crc, builds queue entries
// depends on scf_pkg
`timescale 1ns / 1ps
`default_nettype none

module scf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [7:0]      i_msg_byte,
    input  wire logic            i_q_full,
    output scf_pkg::t_entry      o_q_entry,
    output logic                 o_q_push
);

    logic [4:0]  r_pos, n_pos;
    logic [23:0] r_crc, n_crc;
    logic        is_last;
    logic [23:0] crc_full, crc_end;

    assign o_q_push = i_push && !i_q_full;
    assign is_last  = (r_pos >= scf_pkg::LAST_POS);
    assign crc_full = scf_pkg::crc_byte(r_crc, i_msg_byte);
    assign crc_end  = scf_pkg::crc_top2(r_crc, i_msg_byte);

    always_comb begin
        o_q_entry.last = is_last;
        o_q_entry.data = is_last ? (i_msg_byte & scf_pkg::MSG_MASK) : i_msg_byte;
        o_q_entry.crc  = is_last ? crc_end : crc_full;
        n_pos = r_pos;
        n_crc = r_crc;
        if (o_q_push) begin
            if (is_last) begin
                n_pos = '0;
                n_crc = '0;
            end else begin
                n_pos = r_pos + 5'd1;
                n_crc = crc_full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= '0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

endmodule

`default_nettype wire

/* design/scf_queue.sv */
// short register queue between front and back end
// depends on scf_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sbas_message_crc24q_framer_core_defines.svh"

module scf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  scf_pkg::t_entry      i_entry,
    input  wire logic            i_pop,
    output scf_pkg::t_entry      o_entry,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    scf_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `SCF_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `SCF_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + CW'(1))

endmodule

`default_nettype wire

/* design/scf_back.sv */
// back end: takes queue entries, expands the final one into four data+crc bytes
// depends on scf_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sbas_message_crc24q_framer_core_defines.svh"

module scf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  scf_pkg::t_entry      i_q_entry,
    input  wire logic            i_q_empty,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_out_byte,
    output logic                 o_frame_end
);

    scf_pkg::t_entry r_entry;
    logic            r_valid, n_valid;
    logic [1:0]      r_sub, n_sub;
    logic            done, take;

    assign done    = !r_entry.last || (r_sub == scf_pkg::SUB_LAST);
    assign take    = !r_valid || (i_pop && done);
    assign o_q_pop = take && !i_q_empty;
    assign o_empty = !r_valid;

    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        if (take) begin
            n_valid = !i_q_empty;
            n_sub   = '0;
        end else if (i_pop) begin
            n_sub = r_sub + 2'd1;
        end
    end

    always_comb begin
        o_frame_end = r_entry.last && (r_sub == scf_pkg::SUB_LAST);
        if (!r_entry.last) begin
            o_out_byte = r_entry.data;
        end else begin
            case (r_sub)
                2'd0:    o_out_byte = {r_entry.data[7:6], r_entry.crc[23:18]};
                2'd1:    o_out_byte = r_entry.crc[17:10];
                2'd2:    o_out_byte = r_entry.crc[9:2];
                default: o_out_byte = {r_entry.crc[1:0], 6'b0};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_entry <= i_q_entry;
        end
    end

    `SCF_ASSERT_NOW(a_sub_only_last, i_clk, i_rst_n, r_valid && (r_sub != 2'd0), r_entry.last)
    `SCF_ASSERT_NEXT(a_tail_holds, i_clk, i_rst_n, r_valid && !done && !i_pop, r_valid && $stable(r_sub))

endmodule

`default_nettype wire

/* design/sbas_message_crc24q_framer_core.sv */
// Frames a 226-bit SBAS message given as 29 bytes into 32 bytes with a CRC-24Q appended:
// bytes 0 to 27 pass through, byte 28 (top two bits only) yields four bytes ending the
// frame. One byte is accepted per cycle while the queue is not full; the CRC over a
// whole byte is updated in the same cycle. Each pass-through byte gives one result per
// cycle while pop is held and entries wait, the final byte gives four results from the
// back end, and the queue of QUEUE_DEPTH entries keeps taking input until full.
// depends on scf_pkg, scf_front, scf_queue, scf_back
`timescale 1ns / 1ps
`default_nettype none

module sbas_message_crc24q_framer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       o_out_byte,
    output logic             o_frame_end
);

    scf_pkg::t_entry q_in, q_out;
    logic            q_push, q_pop, q_full, q_empty;

    assign full = q_full;

    scf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_msg_byte (i_msg_byte),
        .i_q_full   (q_full),
        .o_q_entry  (q_in),
        .o_q_push   (q_push)
    );

    scf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    scf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_entry   (q_out),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire
